FILE: hw/rtl/cbin_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbin_pkg;

  // Geometry of the two crystal arrays and of the midplane grid.
  localparam int ARRAY_ROWS = 59;
  localparam int ARRAY_COLS = 26;
  localparam int COUNT_BITS = 32;

  localparam int DET_BINS  = ARRAY_ROWS * ARRAY_COLS;
  localparam int PROJ_ROWS = 2 * ARRAY_ROWS - 1;
  localparam int PROJ_COLS = 2 * ARRAY_COLS - 1;
  localparam int PROJ_BINS = PROJ_ROWS * PROJ_COLS;

  localparam int DET_AW  = $clog2(DET_BINS);
  localparam int PROJ_AW = $clog2(PROJ_BINS);
  localparam int ROW_W   = $clog2(ARRAY_ROWS);
  localparam int COL_W   = $clog2(ARRAY_COLS);
  localparam int GEO_W   = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int D2_W    = 2 * GEO_W + 1;

  // Field widths of the channels.
  localparam int CODE_W   = 16;
  localparam int TIME_W   = 32;
  localparam int SEL_W    = 2;
  localparam int RADDR_W  = 13;
  localparam int STATUS_W = 3;
  localparam int BIN_W    = 13;
  localparam int VALUE_W  = 32;

  // Configuration registers.
  localparam int LIMIT_W    = 31;
  localparam int ACCEPT_W   = 12;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_ACQ_LIMIT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_LIMIT = 4'd1;

  localparam logic [LIMIT_W-1:0]  ACQ_LIMIT_RESET = 31'd72000000;
  localparam logic [ACCEPT_W-1:0] ACCEPT_RESET    = 12'd4;

  // Division of a crystal code by the row count through a reciprocal.
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_MULT  = (1 << RECIP_SHIFT) / ARRAY_ROWS;
  localparam int PROD_W      = CODE_W + RECIP_SHIFT;

  // Output queue.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_BINNED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SKIP    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVER    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_READ    = 3'd5;

  // Histogram selection codes of a read word.
  localparam logic [SEL_W-1:0] SEL_FIRST  = 2'd0;
  localparam logic [SEL_W-1:0] SEL_SECOND = 2'd1;
  localparam logic [SEL_W-1:0] SEL_PROJ   = 2'd2;

  typedef struct packed {
    logic                      func;
    logic signed [TIME_W-1:0]  event_time;
    logic [CODE_W-1:0]         crystal_code_first;
    logic [CODE_W-1:0]         crystal_code_second;
    logic [SEL_W-1:0]          read_select;
    logic [RADDR_W-1:0]        read_address;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BIN_W-1:0]    projection_bin;
    logic [VALUE_W-1:0]  count_value;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cbin_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cbin_in_if import cbin_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [TIME_W-1:0] event_time;
  logic [CODE_W-1:0]        crystal_code_first;
  logic [CODE_W-1:0]        crystal_code_second;
  logic [SEL_W-1:0]         read_select;
  logic [RADDR_W-1:0]       read_address;

  modport source (
    output valid, func, event_time, crystal_code_first, crystal_code_second,
           read_select, read_address,
    input  ready
  );

  modport sink (
    input  valid, func, event_time, crystal_code_first, crystal_code_second,
           read_select, read_address,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/cbin_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cbin_out_if import cbin_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BIN_W-1:0]    projection_bin;
  logic [VALUE_W-1:0]  count_value;

  modport source (
    output valid, status, projection_bin, count_value,
    input  ready
  );

  modport sink (
    input  valid, status, projection_bin, count_value,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/cbin_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cbin_ram #(
  parameter int DEPTH = 2,
  parameter int AW    = 1,
  parameter int DW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // One write and one registered read per cycle; a read of the entry being
  // written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cbin_geom.sv
`timescale 1ns / 1ps
`default_nettype none

module cbin_geom import cbin_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic [CODE_W-1:0]  code_first_i,
  input  wire logic [CODE_W-1:0]  code_second_i,
  output logic      [D2_W-1:0]    dist_sq_o,
  output logic      [PROJ_AW-1:0] proj_idx_o
);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } rc_t;

  logic [CODE_W-1:0]  c1_q, c2_q;
  logic [PROD_W-1:0]  prod1_q, prod2_q;
  rc_t                rc1, rc2;
  logic [ROW_W-1:0]   row1_q, row2_q;
  logic [COL_W-1:0]   col1_q, col2_q;
  logic [ROW_W-1:0]   dr;
  logic [COL_W-1:0]   dc;
  logic [D2_W-1:0]    dr_ext, dc_ext;
  logic [D2_W-1:0]    dist_sq_d, dist_sq_q;
  logic [ROW_W:0]     row_sum;
  logic [COL_W:0]     col_sum;
  logic [PROJ_AW-1:0] proj_idx_d, proj_idx_q;

  // The reciprocal estimate is at most one short, so one correction step
  // gives the exact quotient and remainder.
  function automatic rc_t split_code(input logic [CODE_W-1:0] code,
                                     input logic [PROD_W-1:0] prod);
    logic [31:0] quot;
    logic [31:0] rem;
    rc_t         rc;
    quot = 32'(prod[PROD_W-1:RECIP_SHIFT]);
    rem  = 32'(code) - quot * 32'(ARRAY_ROWS);
    if (rem >= 32'(ARRAY_ROWS)) begin
      quot = quot + 32'd1;
      rem  = rem - 32'(ARRAY_ROWS);
    end
    rc.row = ROW_W'(rem);
    rc.col = COL_W'(quot);
    return rc;
  endfunction

  // First stage: multiply each code by the reciprocal of the row count.
  always_ff @(posedge clk_i) begin
    c1_q    <= code_first_i;
    c2_q    <= code_second_i;
    prod1_q <= PROD_W'(code_first_i) * PROD_W'(RECIP_MULT);
    prod2_q <= PROD_W'(code_second_i) * PROD_W'(RECIP_MULT);
  end

  // Second stage: rows and columns, with the second row mirrored.
  always_comb begin
    rc1 = split_code(c1_q, prod1_q);
    rc2 = split_code(c2_q, prod2_q);
  end

  always_ff @(posedge clk_i) begin
    row1_q <= rc1.row;
    col1_q <= rc1.col;
    row2_q <= ROW_W'(ARRAY_ROWS - 1) - rc2.row;
    col2_q <= rc2.col;
  end

  // Third stage: squared distance and midplane bin.
  always_comb begin
    dr         = (row1_q > row2_q) ? (row1_q - row2_q) : (row2_q - row1_q);
    dc         = (col1_q > col2_q) ? (col1_q - col2_q) : (col2_q - col1_q);
    dr_ext     = D2_W'(dr);
    dc_ext     = D2_W'(dc);
    dist_sq_d  = dr_ext * dr_ext + dc_ext * dc_ext;
    row_sum    = (ROW_W + 1)'(row1_q) + (ROW_W + 1)'(row2_q);
    col_sum    = (COL_W + 1)'(col1_q) + (COL_W + 1)'(col2_q);
    proj_idx_d = PROJ_AW'(32'(row_sum) * 32'(PROJ_COLS) + 32'(col_sum));
  end

  always_ff @(posedge clk_i) begin
    dist_sq_q  <= dist_sq_d;
    proj_idx_q <= proj_idx_d;
  end

  assign dist_sq_o  = dist_sq_q;
  assign proj_idx_o = proj_idx_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cbin_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module cbin_fifo import cbin_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t word_i,
  cbin_out_if.source   out_o
);

  result_t            fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   fill_q, fill_d;
  logic               pop;
  result_t            head;

  assign head            = fifo_q[rd_ptr_q];
  assign out_o.valid          = (fill_q != '0);
  assign out_o.status         = head.status;
  assign out_o.projection_bin = head.projection_bin;
  assign out_o.count_value    = head.count_value;
  assign pop                  = out_o.valid && out_o.ready;

  // Pointer and fill bookkeeping; the producer never pushes into a full queue.
  always_comb begin
    wr_ptr_d = push_i ? (wr_ptr_q + FIFO_AW'(1)) : wr_ptr_q;
    rd_ptr_d = pop ? (rd_ptr_q + FIFO_AW'(1)) : rd_ptr_q;
    fill_d   = fill_q + (FIFO_AW + 1)'(push_i) - (FIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Storage of the queued words.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q] <= word_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/coincidence_event_binner_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake         Word
// in_i     input      valid / ready     func, event_time, crystal codes, read select/address
// out_o    output     valid / ready     status, projection_bin, count_value
// cfg      input      cfg_we_i only     cfg_index_i, cfg_wdata_i
//
// One word is taken per clock while in_i.ready is high; its result passes the
// pipeline stages and the output queue before reaching out_o. The rate is set by
// the histogram read-modify-writes, each forwarded from the previous write.
// Up to eight words may be in flight or queued; in_i.ready drops when that
// credit is used up, so a stalled output holds back the input.
// After reset a clearing pass over the 5967 projection bins zeroes the
// histograms; no word is taken during it.
module coincidence_event_binner_unit import cbin_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  cbin_in_if.sink                    in_i,
  cbin_out_if.source                 out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int OUT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration and control state.
  logic [LIMIT_W-1:0]    acq_limit_q;
  logic [ACCEPT_W-1:0]   accept_limit_q;
  logic                  acq_over_q, acq_over_d;
  logic                  clearing_q, clearing_d;
  logic [PROJ_AW-1:0]    clr_q, clr_d;
  logic [OUT_W-1:0]      outstanding_q, outstanding_d;
  logic                  in_accept, out_accept;

  // Pipeline stages.
  logic                  s1_valid_q;
  in_word_t              s1_q;
  logic [STATUS_W-1:0]   s1_status;
  logic                  s1_det_range;
  logic [DET_AW-1:0]     s1_a1, s1_a2;

  logic                  s2_valid_q;
  logic [STATUS_W-1:0]   s2_status_q;
  logic [SEL_W-1:0]      s2_sel_q;
  logic [RADDR_W-1:0]    s2_raddr_q;
  logic                  s2_det_range_q;
  logic [DET_AW-1:0]     s2_a1_q, s2_a2_q;
  logic [COUNT_BITS-1:0] s2_v1, s2_v2;
  logic [VALUE_W-1:0]    s2_count;
  logic                  s2_bump;

  logic                  s3_valid_q;
  logic [STATUS_W-1:0]   s3_status_q;
  logic [SEL_W-1:0]      s3_sel_q;
  logic [RADDR_W-1:0]    s3_raddr_q;
  logic [VALUE_W-1:0]    s3_count_q;

  logic                  s4_valid_q;
  logic [STATUS_W-1:0]   s4_status_q;
  logic [SEL_W-1:0]      s4_sel_q;
  logic [RADDR_W-1:0]    s4_raddr_q;
  logic [VALUE_W-1:0]    s4_count_q;
  logic [STATUS_W-1:0]   s4_status;
  logic [PROJ_AW-1:0]    s4_paddr;
  logic                  s4_pread;

  logic                  s5_valid_q;
  logic [STATUS_W-1:0]   s5_status_q;
  logic [PROJ_AW-1:0]    s5_paddr_q;
  logic                  s5_pread_q;
  logic [VALUE_W-1:0]    s5_count_q;
  logic [COUNT_BITS-1:0] s5_pv;
  logic                  s5_bump;
  result_t               s5_word;

  // Geometry results, aligned with stage four.
  logic [D2_W-1:0]       dist_sq;
  logic [PROJ_AW-1:0]    proj_idx;

  // Memory ports and last-write forwarding registers.
  logic                  det1_we, det2_we, proj_we;
  logic [DET_AW-1:0]     det1_wa, det2_wa;
  logic [PROJ_AW-1:0]    proj_wa;
  logic [COUNT_BITS-1:0] det1_wd, det2_wd, proj_wd;
  logic [COUNT_BITS-1:0] det1_rd, det2_rd, proj_rd;
  logic                  lw1_valid_q, lw2_valid_q, lwp_valid_q;
  logic [DET_AW-1:0]     lw1_addr_q, lw2_addr_q;
  logic [PROJ_AW-1:0]    lwp_addr_q;
  logic [COUNT_BITS-1:0] lw1_data_q, lw2_data_q, lwp_data_q;
  logic                  clr_det;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : (v + COUNT_BITS'(1));
  endfunction

  function automatic logic [VALUE_W-1:0] sat_word(input logic [COUNT_BITS-1:0] v);
    logic [63:0] wide;
    wide = 64'(v);
    return (wide > 64'hFFFF_FFFF) ? '1 : wide[VALUE_W-1:0];
  endfunction

  // Handshake and credit for words in flight or queued.
  assign in_i.ready = !clearing_q && (outstanding_q < OUT_W'(FIFO_DEPTH));
  assign in_accept  = in_i.valid && in_i.ready;
  assign out_accept = out_o.valid && out_o.ready;

  always_comb begin
    outstanding_d = outstanding_q + OUT_W'(in_accept) - OUT_W'(out_accept);
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acq_limit_q    <= ACQ_LIMIT_RESET;
      accept_limit_q <= ACCEPT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ACQ_LIMIT:    acq_limit_q    <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_ACCEPT_LIMIT: accept_limit_q <= cfg_wdata_i[ACCEPT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clearing pass over the histograms after reset.
  always_comb begin
    clearing_d = clearing_q;
    clr_d      = clr_q;
    if (clearing_q) begin
      clr_d = clr_q + PROJ_AW'(1);
      if (clr_q == PROJ_AW'(PROJ_BINS - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  assign clr_det = (32'(clr_q) < 32'(DET_BINS));

  // Stage one: classify the word and track the end of acquisition.
  always_comb begin
    acq_over_d = acq_over_q;
    if (s1_q.func) begin
      s1_status = ST_READ;
    end else if (acq_over_q) begin
      s1_status = ST_OVER;
    end else if (!s1_q.event_time[TIME_W-1] &&
                 (s1_q.event_time[LIMIT_W-1:0] > acq_limit_q)) begin
      s1_status = ST_OVER;
      if (s1_valid_q) begin
        acq_over_d = 1'b1;
      end
    end else if (&s1_q.event_time) begin
      s1_status = ST_SKIP;
    end else if ((32'(s1_q.crystal_code_first) >= 32'(DET_BINS)) ||
                 (32'(s1_q.crystal_code_second) >= 32'(DET_BINS))) begin
      s1_status = ST_BAD;
    end else begin
      // Counted; stage four decides between binned and outside the cone.
      s1_status = ST_BINNED;
    end
    s1_det_range = (32'(s1_q.read_address) < 32'(DET_BINS));
    s1_a1 = s1_q.func ? DET_AW'(s1_q.read_address) : DET_AW'(s1_q.crystal_code_first);
    s1_a2 = s1_q.func ? DET_AW'(s1_q.read_address) : DET_AW'(s1_q.crystal_code_second);
  end

  // Stage two: detector read-modify-write with forwarding of the last write.
  always_comb begin
    s2_v1   = (lw1_valid_q && (lw1_addr_q == s2_a1_q)) ? lw1_data_q : det1_rd;
    s2_v2   = (lw2_valid_q && (lw2_addr_q == s2_a2_q)) ? lw2_data_q : det2_rd;
    s2_bump = s2_valid_q && (s2_status_q == ST_BINNED);
    s2_count = '0;
    if ((s2_status_q == ST_READ) && s2_det_range_q) begin
      case (s2_sel_q)
        SEL_FIRST:  s2_count = sat_word(s2_v1);
        SEL_SECOND: s2_count = sat_word(s2_v2);
        default:    s2_count = '0;
      endcase
    end
  end

  always_comb begin
    if (clearing_q) begin
      det1_we = clr_det;
      det2_we = clr_det;
      det1_wa = DET_AW'(clr_q);
      det2_wa = DET_AW'(clr_q);
      det1_wd = '0;
      det2_wd = '0;
    end else begin
      det1_we = s2_bump;
      det2_we = s2_bump;
      det1_wa = s2_a1_q;
      det2_wa = s2_a2_q;
      det1_wd = sat_inc(s2_v1);
      det2_wd = sat_inc(s2_v2);
    end
  end

  // Stage four: cone decision and projection read address.
  always_comb begin
    s4_status = s4_status_q;
    if ((s4_status_q == ST_BINNED) && (32'(dist_sq) > 32'(accept_limit_q))) begin
      s4_status = ST_OUTSIDE;
    end
    s4_pread = (s4_status_q == ST_READ) && (s4_sel_q == SEL_PROJ) &&
               (32'(s4_raddr_q) < 32'(PROJ_BINS));
    s4_paddr = (s4_status_q == ST_READ) ? PROJ_AW'(s4_raddr_q) : proj_idx;
  end

  // Stage five: projection read-modify-write and the result word.
  always_comb begin
    s5_pv   = (lwp_valid_q && (lwp_addr_q == s5_paddr_q)) ? lwp_data_q : proj_rd;
    s5_bump = s5_valid_q && (s5_status_q == ST_BINNED);
    if (clearing_q) begin
      proj_we = 1'b1;
      proj_wa = clr_q;
      proj_wd = '0;
    end else begin
      proj_we = s5_bump;
      proj_wa = s5_paddr_q;
      proj_wd = sat_inc(s5_pv);
    end
    s5_word.status         = s5_status_q;
    s5_word.projection_bin = (s5_status_q == ST_BINNED) ? BIN_W'(s5_paddr_q) : '0;
    s5_word.count_value    = s5_pread_q ? sat_word(s5_pv) : s5_count_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acq_over_q    <= 1'b0;
      clearing_q    <= 1'b1;
      clr_q         <= '0;
      outstanding_q <= '0;
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      s3_valid_q    <= 1'b0;
      s4_valid_q    <= 1'b0;
      s5_valid_q    <= 1'b0;
      lw1_valid_q   <= 1'b0;
      lw2_valid_q   <= 1'b0;
      lwp_valid_q   <= 1'b0;
    end else begin
      acq_over_q    <= acq_over_d;
      clearing_q    <= clearing_d;
      clr_q         <= clr_d;
      outstanding_q <= outstanding_d;
      s1_valid_q    <= in_accept;
      s2_valid_q    <= s1_valid_q;
      s3_valid_q    <= s2_valid_q;
      s4_valid_q    <= s3_valid_q;
      s5_valid_q    <= s4_valid_q;
      lw1_valid_q   <= det1_we && !clearing_q;
      lw2_valid_q   <= det2_we && !clearing_q;
      lwp_valid_q   <= proj_we && !clearing_q;
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.func                <= in_i.func;
      s1_q.event_time          <= in_i.event_time;
      s1_q.crystal_code_first  <= in_i.crystal_code_first;
      s1_q.crystal_code_second <= in_i.crystal_code_second;
      s1_q.read_select         <= in_i.read_select;
      s1_q.read_address        <= in_i.read_address;
    end
    s2_status_q    <= s1_status;
    s2_sel_q       <= s1_q.read_select;
    s2_raddr_q     <= s1_q.read_address;
    s2_det_range_q <= s1_det_range;
    s2_a1_q        <= s1_a1;
    s2_a2_q        <= s1_a2;

    s3_status_q <= s2_status_q;
    s3_sel_q    <= s2_sel_q;
    s3_raddr_q  <= s2_raddr_q;
    s3_count_q  <= s2_count;

    s4_status_q <= s3_status_q;
    s4_sel_q    <= s3_sel_q;
    s4_raddr_q  <= s3_raddr_q;
    s4_count_q  <= s3_count_q;

    s5_status_q <= s4_status;
    s5_paddr_q  <= s4_paddr;
    s5_pread_q  <= s4_pread;
    s5_count_q  <= s4_count_q;

    lw1_addr_q <= det1_wa;
    lw1_data_q <= det1_wd;
    lw2_addr_q <= det2_wa;
    lw2_data_q <= det2_wd;
    lwp_addr_q <= proj_wa;
    lwp_data_q <= proj_wd;
  end

  // Crystal geometry pipeline, fed from stage one.
  cbin_geom u_geom (
    .clk_i         (clk_i),
    .code_first_i  (s1_q.crystal_code_first),
    .code_second_i (s1_q.crystal_code_second),
    .dist_sq_o     (dist_sq),
    .proj_idx_o    (proj_idx)
  );

  // Histogram memories.
  cbin_ram #(.DEPTH(DET_BINS), .AW(DET_AW), .DW(COUNT_BITS)) u_first_hist (
    .clk_i   (clk_i),
    .we_i    (det1_we),
    .waddr_i (det1_wa),
    .wdata_i (det1_wd),
    .raddr_i (s1_a1),
    .rdata_o (det1_rd)
  );

  cbin_ram #(.DEPTH(DET_BINS), .AW(DET_AW), .DW(COUNT_BITS)) u_second_hist (
    .clk_i   (clk_i),
    .we_i    (det2_we),
    .waddr_i (det2_wa),
    .wdata_i (det2_wd),
    .raddr_i (s1_a2),
    .rdata_o (det2_rd)
  );

  cbin_ram #(.DEPTH(PROJ_BINS), .AW(PROJ_AW), .DW(COUNT_BITS)) u_proj_hist (
    .clk_i   (clk_i),
    .we_i    (proj_we),
    .waddr_i (proj_wa),
    .wdata_i (proj_wd),
    .raddr_i (s4_paddr),
    .rdata_o (proj_rd)
  );

  // Output queue.
  cbin_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s5_valid_q),
    .word_i (s5_word),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
